### rtl/clp_pkg.sv
// ----------------------------------------------------------------------------
// clp_pkg
// Field widths, request and status codes and the result type shared by the
// cursor list blocks.
// ----------------------------------------------------------------------------
package clp_pkg;

  localparam int FUNC_W     = 3;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int SLOT_W     = 4;
  localparam int MAX_DUMP   = 16;
  localparam int DUMP_CNT_W = $clog2(MAX_DUMP);

  localparam logic [FUNC_W-1:0] FUNC_INS_HEAD   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_INS_TAIL   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_INS_SORTED = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_DEL_HEAD   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_DEL_TAIL   = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_DUMP       = 3'd5;

  localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [SLOT_W-1:0]        slot;
    logic signed [VALUE_W-1:0] value_out;
    logic                     last;
  } res_t;

endpackage

### rtl/clp_if.sv
// ----------------------------------------------------------------------------
// clp_if
// Request and result channels of the cursor list, valid/ready handshake.
// ----------------------------------------------------------------------------
interface clp_req_if import clp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [FUNC_W-1:0]         func;
  logic signed [VALUE_W-1:0] value_in;

  modport source (output valid, func, value_in, input ready);
  modport sink (input valid, func, value_in, output ready);
endinterface

interface clp_res_if import clp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic [SLOT_W-1:0]         slot;
  logic signed [VALUE_W-1:0] value_out;
  logic                      last;

  modport source (output valid, status, slot, value_out, last, input ready);
  modport sink (input valid, status, slot, value_out, last, output ready);
endinterface

### rtl/clp_store.sv
// ----------------------------------------------------------------------------
// clp_store
// Node pool: value memory and link memory with one shared registered read
// port; link entries carry valid bits so unwritten links read as slot + 1.
// ----------------------------------------------------------------------------
module clp_store import clp_pkg::*; #(
  parameter int POOL_NODES = 16,
  parameter int LW         = $clog2(POOL_NODES + 1),
  parameter int AW         = $clog2(POOL_NODES)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [LW-1:0]             rd_link,
  output logic signed [VALUE_W-1:0] rd_value,
  input  logic                      link_we,
  input  logic [AW-1:0]             link_waddr,
  input  logic [LW-1:0]             link_wdata,
  input  logic                      val_we,
  input  logic [AW-1:0]             val_waddr,
  input  logic signed [VALUE_W-1:0] val_wdata
);

  logic signed [VALUE_W-1:0] value_mem [POOL_NODES];
  logic [LW-1:0]             link_mem  [POOL_NODES];
  logic [POOL_NODES-1:0]     link_valid;

  always_ff @(posedge clk) begin
    if (val_we) begin
      value_mem[val_waddr] <= val_wdata;
    end
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (rd_en) begin
      rd_value <= value_mem[rd_addr];
      // untouched entries still hold the reset chain i -> i+1
      rd_link  <= link_valid[rd_addr] ? link_mem[rd_addr] : LW'(rd_addr) + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_valid <= '0;
    end else if (link_we) begin
      link_valid[link_waddr] <= 1'b1;
    end
  end

endmodule

### rtl/clp_seq.sv
// ----------------------------------------------------------------------------
// clp_seq
// Request sequencer: allocates and frees slots, walks the list one node per
// read of the pool and emits result beats.
// ----------------------------------------------------------------------------
module clp_seq import clp_pkg::*; #(
  parameter int POOL_NODES = 16,
  parameter int LW         = $clog2(POOL_NODES + 1),
  parameter int AW         = $clog2(POOL_NODES)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [FUNC_W-1:0]         in_func,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                      res_valid,
  input  logic                      res_ready,
  output res_t                      res_data,
  output logic                      rd_en,
  output logic [AW-1:0]             rd_addr,
  input  logic [LW-1:0]             rd_link,
  input  logic signed [VALUE_W-1:0] rd_value,
  output logic                      link_we,
  output logic [AW-1:0]             link_waddr,
  output logic [LW-1:0]             link_wdata,
  output logic                      val_we,
  output logic [AW-1:0]             val_waddr,
  output logic signed [VALUE_W-1:0] val_wdata
);

  localparam logic [LW-1:0] NIL = LW'(POOL_NODES);

  typedef enum logic [2:0] {
    S_IDLE, S_ALLOC, S_WALK_RD, S_WALK_CHK, S_FIN1, S_FIN2, S_EMIT
  } state_t;

  state_t                    state;
  logic [FUNC_W-1:0]         op;
  logic signed [VALUE_W-1:0] val;
  logic [LW-1:0]             cur;
  logic [LW-1:0]             prev;
  logic [LW-1:0]             nxt;
  logic [LW-1:0]             ins;
  logic [LW-1:0]             list_head;
  logic [LW-1:0]             free_head;
  logic [DUMP_CNT_W-1:0]     cnt;
  res_t                      res_q;

  logic is_insert;
  logic is_delete;
  logic in_is_insert;
  logic link_is_slot;
  logic prev_is_slot;

  assign is_insert    = (op == FUNC_INS_HEAD) || (op == FUNC_INS_TAIL) ||
                        (op == FUNC_INS_SORTED);
  assign is_delete    = (op == FUNC_DEL_HEAD) || (op == FUNC_DEL_TAIL);
  assign in_is_insert = (in_func == FUNC_INS_HEAD) || (in_func == FUNC_INS_TAIL) ||
                        (in_func == FUNC_INS_SORTED);
  assign link_is_slot = rd_link < NIL;
  assign prev_is_slot = prev < NIL;

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_EMIT);
  assign res_data  = res_q;

  // pool port control
  always_comb begin
    rd_en      = 1'b0;
    rd_addr    = cur[AW-1:0];
    link_we    = 1'b0;
    link_waddr = ins[AW-1:0];
    link_wdata = cur;
    val_we     = 1'b0;
    val_waddr  = ins[AW-1:0];
    val_wdata  = val;
    case (state)
      S_IDLE: begin
        if (in_is_insert) begin
          rd_addr = free_head[AW-1:0];
          rd_en   = in_valid && (free_head < NIL);
        end else begin
          rd_addr = list_head[AW-1:0];
          rd_en   = in_valid && (list_head < NIL);
        end
      end
      S_ALLOC: val_we = 1'b1;
      S_WALK_RD: rd_en = 1'b1;
      S_FIN1: begin
        if (is_insert) begin
          link_we = 1'b1;
        end else begin
          // unlink: predecessor skips over the removed node
          link_we    = prev_is_slot;
          link_waddr = prev[AW-1:0];
          link_wdata = nxt;
        end
      end
      S_FIN2: begin
        if (is_insert) begin
          link_we    = prev_is_slot;
          link_waddr = prev[AW-1:0];
          link_wdata = ins;
        end else begin
          // freed slot goes to the front of the free list
          link_we    = 1'b1;
          link_waddr = cur[AW-1:0];
          link_wdata = free_head;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      list_head <= NIL;
      free_head <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op   <= in_func;
            val  <= in_value;
            prev <= NIL;
            cnt  <= '0;
            case (in_func)
              FUNC_INS_HEAD, FUNC_INS_TAIL, FUNC_INS_SORTED: begin
                if (free_head < NIL) begin
                  ins   <= free_head;
                  state <= S_ALLOC;
                end else begin
                  res_q <= '{status: STATUS_NO_SPACE, slot: '0, value_out: '0, last: 1'b1};
                  state <= S_EMIT;
                end
              end
              FUNC_DEL_HEAD, FUNC_DEL_TAIL, FUNC_DUMP: begin
                if (list_head < NIL) begin
                  cur   <= list_head;
                  state <= S_WALK_CHK;
                end else begin
                  res_q <= '{status: STATUS_EMPTY, slot: '0, value_out: '0, last: 1'b1};
                  state <= S_EMIT;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_ALLOC: begin
          free_head <= rd_link;
          cur       <= list_head;
          if (op == FUNC_INS_HEAD || list_head >= NIL) begin
            state <= S_FIN1;
          end else begin
            state <= S_WALK_RD;
          end
        end
        S_WALK_RD: state <= S_WALK_CHK;
        S_WALK_CHK: begin
          case (op)
            FUNC_INS_TAIL: begin
              prev  <= cur;
              cur   <= rd_link;
              state <= link_is_slot ? S_WALK_RD : S_FIN1;
            end
            FUNC_INS_SORTED: begin
              // stop ahead of the first element not below the new value
              if (rd_value < val) begin
                prev  <= cur;
                cur   <= rd_link;
                state <= link_is_slot ? S_WALK_RD : S_FIN1;
              end else begin
                state <= S_FIN1;
              end
            end
            FUNC_DEL_HEAD, FUNC_DEL_TAIL: begin
              nxt <= rd_link;
              if (op == FUNC_DEL_TAIL && link_is_slot) begin
                prev  <= cur;
                cur   <= rd_link;
                state <= S_WALK_RD;
              end else begin
                state <= S_FIN1;
              end
            end
            FUNC_DUMP: begin
              res_q <= '{status: STATUS_DONE, slot: SLOT_W'(cur), value_out: rd_value,
                         last: !link_is_slot || (cnt == DUMP_CNT_W'(MAX_DUMP - 1))};
              cur   <= rd_link;
              cnt   <= cnt + DUMP_CNT_W'(1);
              state <= S_EMIT;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_FIN1: begin
          if (is_delete && !prev_is_slot) begin
            list_head <= nxt;
          end
          state <= S_FIN2;
        end
        S_FIN2: begin
          if (is_insert) begin
            if (!prev_is_slot) begin
              list_head <= ins;
            end
            res_q <= '{status: STATUS_DONE, slot: SLOT_W'(ins), value_out: '0, last: 1'b1};
          end else begin
            free_head <= cur;
            res_q     <= '{status: STATUS_DONE, slot: SLOT_W'(cur), value_out: '0, last: 1'b1};
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (res_ready) begin
            state <= (op == FUNC_DUMP && !res_q.last) ? S_WALK_RD : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // data list and free list never share a slot
  a_heads_apart: assert property (@(posedge clk) disable iff (rst)
    (list_head < NIL && free_head < NIL) |-> list_head != free_head)
    else $error("list head and free head point at the same slot");

  a_fail_beat: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.status != STATUS_DONE) |-> (res_data.slot == '0 && res_data.last))
    else $error("failure beat with nonzero slot or without last");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(in_valid))
    else $error("sequencer left idle without a request");

  a_no_write_in_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !link_we && !val_we)
    else $error("pool written while idle");

endmodule

### rtl/cursor_list_with_free_pool_top.sv
// ----------------------------------------------------------------------------
// cursor_list_with_free_pool_top
// Cursor linked list over a fixed node pool with a free list: insert at head,
// tail or in order, delete head or tail, dump the list.
//
// channel  dir  beat contents
// req      in   func, value_in
// res      out  status, slot, value_out, last
//
// Insert head and delete head work at the front of the list; insert tail or
// sorted and delete tail walk the list (sorted may stop early), and dump
// emits one beat per element. The walk reads one node at a time through the pool's single read port.
// Reset is immediate: link valid bits stand in for the initial free chain.
// Results sit in an output register; the sequencer stalls only when it holds
// a beat that the downstream side has not yet taken.
// ----------------------------------------------------------------------------
module cursor_list_with_free_pool_top import clp_pkg::*; #(
  parameter int POOL_NODES = 16
) (
  input logic        clk,
  input logic        rst,
  clp_req_if.sink    req,
  clp_res_if.source  res
);

  localparam int LW = $clog2(POOL_NODES + 1);
  localparam int AW = $clog2(POOL_NODES);

  logic                      seq_valid;
  logic                      seq_ready;
  res_t                      seq_data;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic [LW-1:0]             rd_link;
  logic signed [VALUE_W-1:0] rd_value;
  logic                      link_we;
  logic [AW-1:0]             link_waddr;
  logic [LW-1:0]             link_wdata;
  logic                      val_we;
  logic [AW-1:0]             val_waddr;
  logic signed [VALUE_W-1:0] val_wdata;

  logic out_full;
  res_t out_data;

  clp_seq #(.POOL_NODES(POOL_NODES), .LW(LW), .AW(AW)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_ready   (req.ready),
    .in_func    (req.func),
    .in_value   (req.value_in),
    .res_valid  (seq_valid),
    .res_ready  (seq_ready),
    .res_data   (seq_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_link    (rd_link),
    .rd_value   (rd_value),
    .link_we    (link_we),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .val_we     (val_we),
    .val_waddr  (val_waddr),
    .val_wdata  (val_wdata)
  );

  clp_store #(.POOL_NODES(POOL_NODES), .LW(LW), .AW(AW)) u_store (
    .clk        (clk),
    .rst        (rst),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_link    (rd_link),
    .rd_value   (rd_value),
    .link_we    (link_we),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .val_we     (val_we),
    .val_waddr  (val_waddr),
    .val_wdata  (val_wdata)
  );

  // output register, refilled in the same cycle it drains
  assign seq_ready = !out_full || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (seq_valid && seq_ready) begin
      out_full <= 1'b1;
    end else if (res.ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_valid && seq_ready) begin
      out_data <= seq_data;
    end
  end

  assign res.valid     = out_full;
  assign res.status    = out_data.status;
  assign res.slot      = out_data.slot;
  assign res.value_out = out_data.value_out;
  assign res.last      = out_data.last;

endmodule
